/* sv/segx_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and latencies of the segment intersection pipeline
package segx_pkg;

    localparam int COORD_W = 32;                  // q16.16 coordinate
    localparam int DELTA_W = COORD_W + 1;         // difference of two coordinates
    localparam int COEF_W  = 2 * COORD_W + 2;     // line constant c
    localparam int DET_W   = 2 * DELTA_W + 1;     // determinant d
    localparam int NUM_W   = COEF_W + DELTA_W + 1; // determinants dx and dy
    localparam int Q_BITS  = COORD_W + 1;         // quotient bits kept by the divider
    localparam int BND_W   = COORD_W + 2;         // widened box bound
    localparam int TOL_W   = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    localparam int COEF_LAT  = 3;
    localparam int DET_LAT   = 3;
    localparam int DIV_LAT   = Q_BITS + 3;
    localparam int FRONT_LAT = COEF_LAT + DET_LAT + DIV_LAT;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [DET_W-1:0]   t_det;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic signed [BND_W-1:0]   t_bound;

    typedef struct packed {
        t_coord ax0;
        t_coord ay0;
        t_coord az0;
        t_coord ax1;
        t_coord ay1;
        t_coord bx0;
        t_coord by0;
        t_coord bx1;
        t_coord by1;
    } t_pts;

endpackage

/* sv/segx_coef.sv */
`timescale 1ns / 1ps
// line coefficients and main determinant, three stages
module segx_coef (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  segx_pkg::t_pts   i_pts,
    output logic             o_valid,
    output segx_pkg::t_delta o_a1,
    output segx_pkg::t_delta o_b1,
    output segx_pkg::t_delta o_a2,
    output segx_pkg::t_delta o_b2,
    output segx_pkg::t_coef  o_c1,
    output segx_pkg::t_coef  o_c2,
    output segx_pkg::t_det   o_d
);

    logic r1_valid, r2_valid, r3_valid;

    segx_pkg::t_coord r1_ax0, r1_ay0, r1_bx0, r1_by0;
    segx_pkg::t_delta r1_a1, r1_b1, r1_a2, r1_b2;

    logic signed [2*segx_pkg::COORD_W:0] r2_p1, r2_p2, r2_p3, r2_p4;
    logic signed [2*segx_pkg::DELTA_W-1:0] r2_m1, r2_m2;
    segx_pkg::t_delta r2_a1, r2_b1, r2_a2, r2_b2;

    segx_pkg::t_coef  r3_c1, r3_c2;
    segx_pkg::t_det   r3_d;
    segx_pkg::t_delta r3_a1, r3_b1, r3_a2, r3_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // a = y1 - y0, b = x0 - x1
            r1_ax0 <= i_pts.ax0;
            r1_ay0 <= i_pts.ay0;
            r1_bx0 <= i_pts.bx0;
            r1_by0 <= i_pts.by0;
            r1_a1  <= 33'(i_pts.ay1) - 33'(i_pts.ay0);
            r1_b1  <= 33'(i_pts.ax0) - 33'(i_pts.ax1);
            r1_a2  <= 33'(i_pts.by1) - 33'(i_pts.by0);
            r1_b2  <= 33'(i_pts.bx0) - 33'(i_pts.bx1);

            // c = x0*a + y0*b, d = a1*b2 - a2*b1
            r2_p1 <= 65'(r1_ax0) * 65'(r1_a1);
            r2_p2 <= 65'(r1_ay0) * 65'(r1_b1);
            r2_p3 <= 65'(r1_bx0) * 65'(r1_a2);
            r2_p4 <= 65'(r1_by0) * 65'(r1_b2);
            r2_m1 <= 66'(r1_a1) * 66'(r1_b2);
            r2_m2 <= 66'(r1_a2) * 66'(r1_b1);
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;

            r3_c1 <= 66'(r2_p1) + 66'(r2_p2);
            r3_c2 <= 66'(r2_p3) + 66'(r2_p4);
            r3_d  <= 67'(r2_m1) - 67'(r2_m2);
            r3_a1 <= r2_a1;
            r3_b1 <= r2_b1;
            r3_a2 <= r2_a2;
            r3_b2 <= r2_b2;
        end
    end

    assign o_valid = r3_valid;
    assign o_a1    = r3_a1;
    assign o_b1    = r3_b1;
    assign o_a2    = r3_a2;
    assign o_b2    = r3_b2;
    assign o_c1    = r3_c1;
    assign o_c2    = r3_c2;
    assign o_d     = r3_d;

endmodule

/* sv/segx_det.sv */
`timescale 1ns / 1ps
// cramer numerators dx and dy from split products, three stages
module segx_det (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  segx_pkg::t_delta i_a1,
    input  segx_pkg::t_delta i_b1,
    input  segx_pkg::t_delta i_a2,
    input  segx_pkg::t_delta i_b2,
    input  segx_pkg::t_coef  i_c1,
    input  segx_pkg::t_coef  i_c2,
    input  segx_pkg::t_det   i_d,
    output logic             o_valid,
    output segx_pkg::t_num   o_dx,
    output segx_pkg::t_num   o_dy,
    output segx_pkg::t_det   o_d
);

    localparam int LO_W = segx_pkg::DELTA_W;   // low slice of c, unsigned
    localparam int P_W  = segx_pkg::NUM_W - 1;

    // products: c1*b2, c2*b1, a1*c2, a2*c1
    segx_pkg::t_coef  c_sel [4];
    segx_pkg::t_delta b_sel [4];

    logic r4_valid, r5_valid, r6_valid;
    logic signed [segx_pkg::COEF_W-1:0] r4_hi [4];
    logic signed [segx_pkg::COEF_W:0]   r4_lo [4];
    logic signed [P_W-1:0]              r5_p  [4];
    segx_pkg::t_det r4_d, r5_d, r6_d;
    segx_pkg::t_num r6_dx, r6_dy;

    always_comb begin
        c_sel[0] = i_c1;  b_sel[0] = i_b2;
        c_sel[1] = i_c2;  b_sel[1] = i_b1;
        c_sel[2] = i_c2;  b_sel[2] = i_a1;
        c_sel[3] = i_c1;  b_sel[3] = i_a2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r4_hi[k] <= 66'($signed(c_sel[k][segx_pkg::COEF_W-1:LO_W])) * 66'(b_sel[k]);
                r4_lo[k] <= 67'($signed({1'b0, c_sel[k][LO_W-1:0]})) * 67'(b_sel[k]);
                r5_p[k]  <= $signed({r4_hi[k], {LO_W{1'b0}}}) + P_W'(r4_lo[k]);
            end
            r4_d  <= i_d;
            r5_d  <= r4_d;
            r6_d  <= r5_d;
            r6_dx <= segx_pkg::NUM_W'(r5_p[0]) - segx_pkg::NUM_W'(r5_p[1]);
            r6_dy <= segx_pkg::NUM_W'(r5_p[2]) - segx_pkg::NUM_W'(r5_p[3]);
        end
    end

    assign o_valid = r6_valid;
    assign o_dx    = r6_dx;
    assign o_dy    = r6_dy;
    assign o_d     = r6_d;

endmodule

/* sv/segx_div.sv */
`timescale 1ns / 1ps
// two-lane pipelined restoring divider, one quotient bit per stage, saturating
module segx_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  segx_pkg::t_num   i_dx,
    input  segx_pkg::t_num   i_dy,
    input  segx_pkg::t_det   i_d,
    output logic             o_valid,
    output logic             o_dzero,
    output segx_pkg::t_coord o_qx,
    output segx_pkg::t_coord o_qy
);

    localparam int NW = segx_pkg::NUM_W;
    localparam int DW = segx_pkg::DET_W;
    localparam int QB = segx_pkg::Q_BITS;

    function automatic segx_pkg::t_coord f_sat(input logic ovf, input logic neg,
                                               input logic [QB-1:0] q);
        logic [QB-1:0] nq;
        nq = QB'(0) - q;
        if (!neg) begin
            if (ovf || q > QB'(33'h07FFFFFFF)) return 32'h7FFFFFFF;
            return q[segx_pkg::COORD_W-1:0];
        end
        if (ovf || q > QB'(33'h080000000)) return 32'h80000000;
        return nq[segx_pkg::COORD_W-1:0];
    endfunction

    // magnitude stage
    logic          ra_valid, ra_negx, ra_negy, ra_dz;
    logic [NW-1:0] ra_nx, ra_ny;
    logic [DW-1:0] ra_d;

    // step pipeline, index 0 is the overflow stage
    logic          r_valid [QB+1];
    logic          r_negx  [QB+1];
    logic          r_negy  [QB+1];
    logic          r_ovfx  [QB+1];
    logic          r_ovfy  [QB+1];
    logic          r_dz    [QB+1];
    logic [DW-1:0] r_d     [QB+1];
    logic [NW-1:0] r_rx    [QB+1];
    logic [NW-1:0] r_ry    [QB+1];
    logic [QB-1:0] r_qx    [QB+1];
    logic [QB-1:0] r_qy    [QB+1];

    logic             rc_valid, rc_dz;
    segx_pkg::t_coord rc_qx, rc_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid    <= 1'b0;
            r_valid[0]  <= 1'b0;
            rc_valid    <= 1'b0;
        end else if (i_en) begin
            ra_valid    <= i_valid;
            r_valid[0]  <= ra_valid;
            rc_valid    <= r_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_nx   <= i_dx[NW-1] ? NW'(-i_dx) : NW'(i_dx);
            ra_ny   <= i_dy[NW-1] ? NW'(-i_dy) : NW'(i_dy);
            ra_d    <= i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
            ra_negx <= i_dx[NW-1] ^ i_d[DW-1];
            ra_negy <= i_dy[NW-1] ^ i_d[DW-1];
            ra_dz   <= (i_d == '0);

            // quotient needs more than QB bits: saturate
            r_ovfx[0] <= ra_nx >= {ra_d, {QB{1'b0}}};
            r_ovfy[0] <= ra_ny >= {ra_d, {QB{1'b0}}};
            r_negx[0] <= ra_negx;
            r_negy[0] <= ra_negy;
            r_dz[0]   <= ra_dz;
            r_d[0]    <= ra_d;
            r_rx[0]   <= ra_nx;
            r_ry[0]   <= ra_ny;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;

            rc_dz <= r_dz[QB];
            rc_qx <= f_sat(r_ovfx[QB], r_negx[QB], r_qx[QB]);
            rc_qy <= f_sat(r_ovfy[QB], r_negy[QB], r_qy[QB]);
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;

        logic [NW-1:0] dsh;
        logic [NW:0]   tx, ty;
        logic [QB-1:0] nqx, nqy;

        always_comb begin
            dsh = NW'(r_d[j]) << SH;
            tx  = {1'b0, r_rx[j]} - {1'b0, dsh};
            ty  = {1'b0, r_ry[j]} - {1'b0, dsh};
            nqx = r_qx[j];
            nqy = r_qy[j];
            nqx[SH] = !tx[NW];
            nqy[SH] = !ty[NW];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[j+1]   <= tx[NW] ? r_rx[j] : tx[NW-1:0];
                r_ry[j+1]   <= ty[NW] ? r_ry[j] : ty[NW-1:0];
                r_qx[j+1]   <= nqx;
                r_qy[j+1]   <= nqy;
                r_d[j+1]    <= r_d[j];
                r_negx[j+1] <= r_negx[j];
                r_negy[j+1] <= r_negy[j];
                r_ovfx[j+1] <= r_ovfx[j];
                r_ovfy[j+1] <= r_ovfy[j];
                r_dz[j+1]   <= r_dz[j];
            end
        end
    end

    assign o_valid = rc_valid;
    assign o_dzero = rc_dz;
    assign o_qx    = rc_qx;
    assign o_qy    = rc_qy;

endmodule

/* sv/segment_intersection_2d.sv */
`timescale 1ns / 1ps
// top level: 2d segment intersection with saturated q16.16 point and box hit test
// one item per cycle sustained while the result side keeps i_m_axis_tready high
// the divider resolves one of its 33 quotient bits per stage
// the whole pipeline holds in place while a result waits on a low i_m_axis_tready
// reset clears all valid bits and loads tolerance with 66; payload is not reset
module segment_intersection_2d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tolerance register write
    input  logic         i_cfg_wen,
    input  logic [15:0]  i_cfg_wdata,
    // input segment pair
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
    // b_start_x, b_start_y, b_end_x, b_end_y (32 bits each, from bit 0 up)
    input  logic [287:0] i_s_axis_tdata,
    // result
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // cross_x, cross_y, cross_z (32 bits each, from bit 0 up)
    output logic [95:0]  o_m_axis_tdata,
    // hit (bit 0), parallel (bit 1)
    output logic [1:0]   o_m_axis_tuser
);

    localparam int LAT = segx_pkg::FRONT_LAT;

    logic [segx_pkg::TOL_W-1:0]  r_tol;
    logic                        en;
    segx_pkg::t_pts              in_pts;

    // coefficient stage outputs
    logic             cf_valid;
    segx_pkg::t_delta cf_a1, cf_b1, cf_a2, cf_b2;
    segx_pkg::t_coef  cf_c1, cf_c2;
    segx_pkg::t_det   cf_d;

    // determinant stage outputs
    logic             dt_valid;
    segx_pkg::t_num   dt_dx, dt_dy;
    segx_pkg::t_det   dt_d;

    // divider outputs
    logic             dv_valid, dv_dzero;
    segx_pkg::t_coord dv_qx, dv_qy;

    // endpoints travel beside the arithmetic
    segx_pkg::t_pts r_sb [LAT];

    // bound stage
    logic             r_t1_valid, r_t1_par;
    segx_pkg::t_coord r_t1_px, r_t1_py, r_t1_z;
    segx_pkg::t_bound r_t1_alox, r_t1_ahix, r_t1_aloy, r_t1_ahiy;
    segx_pkg::t_bound r_t1_blox, r_t1_bhix, r_t1_bloy, r_t1_bhiy;
    segx_pkg::t_bound tol_ext;
    segx_pkg::t_bound px_ext, py_ext;

    // output register
    logic             r_out_valid, r_out_hit, r_out_par;
    segx_pkg::t_coord r_out_x, r_out_y, r_out_z;

    // everything moves unless a finished result is being held
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign in_pts.ax0 = i_s_axis_tdata[31:0];
    assign in_pts.ay0 = i_s_axis_tdata[63:32];
    assign in_pts.az0 = i_s_axis_tdata[95:64];
    assign in_pts.ax1 = i_s_axis_tdata[127:96];
    assign in_pts.ay1 = i_s_axis_tdata[159:128];
    assign in_pts.bx0 = i_s_axis_tdata[191:160];
    assign in_pts.by0 = i_s_axis_tdata[223:192];
    assign in_pts.bx1 = i_s_axis_tdata[255:224];
    assign in_pts.by1 = i_s_axis_tdata[287:256];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= segx_pkg::TOL_RESET;
        end else if (i_cfg_wen) begin
            r_tol <= i_cfg_wdata;
        end
    end

    segx_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_pts   (in_pts),
        .o_valid (cf_valid),
        .o_a1    (cf_a1),
        .o_b1    (cf_b1),
        .o_a2    (cf_a2),
        .o_b2    (cf_b2),
        .o_c1    (cf_c1),
        .o_c2    (cf_c2),
        .o_d     (cf_d)
    );

    segx_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cf_valid),
        .i_a1    (cf_a1),
        .i_b1    (cf_b1),
        .i_a2    (cf_a2),
        .i_b2    (cf_b2),
        .i_c1    (cf_c1),
        .i_c2    (cf_c2),
        .i_d     (cf_d),
        .o_valid (dt_valid),
        .o_dx    (dt_dx),
        .o_dy    (dt_dy),
        .o_d     (dt_d)
    );

    segx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dt_valid),
        .i_dx    (dt_dx),
        .i_dy    (dt_dy),
        .i_d     (dt_d),
        .o_valid (dv_valid),
        .o_dzero (dv_dzero),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy)
    );

    // endpoint delay line, aligned with the divider output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= in_pts;
            for (int k = 1; k < LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign tol_ext = $signed({{(segx_pkg::BND_W - segx_pkg::TOL_W){1'b0}}, r_tol});

    // widened bounding boxes, inclusive, at 34 bits so they never wrap
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_par  <= dv_dzero;
            r_t1_px   <= dv_dzero ? '0 : dv_qx;
            r_t1_py   <= dv_dzero ? '0 : dv_qy;
            r_t1_z    <= r_sb[LAT-1].az0;
            r_t1_alox <= ((r_sb[LAT-1].ax0 < r_sb[LAT-1].ax1) ? 34'(r_sb[LAT-1].ax0)
                                                               : 34'(r_sb[LAT-1].ax1)) - tol_ext;
            r_t1_ahix <= ((r_sb[LAT-1].ax0 < r_sb[LAT-1].ax1) ? 34'(r_sb[LAT-1].ax1)
                                                               : 34'(r_sb[LAT-1].ax0)) + tol_ext;
            r_t1_aloy <= ((r_sb[LAT-1].ay0 < r_sb[LAT-1].ay1) ? 34'(r_sb[LAT-1].ay0)
                                                               : 34'(r_sb[LAT-1].ay1)) - tol_ext;
            r_t1_ahiy <= ((r_sb[LAT-1].ay0 < r_sb[LAT-1].ay1) ? 34'(r_sb[LAT-1].ay1)
                                                               : 34'(r_sb[LAT-1].ay0)) + tol_ext;
            r_t1_blox <= ((r_sb[LAT-1].bx0 < r_sb[LAT-1].bx1) ? 34'(r_sb[LAT-1].bx0)
                                                               : 34'(r_sb[LAT-1].bx1)) - tol_ext;
            r_t1_bhix <= ((r_sb[LAT-1].bx0 < r_sb[LAT-1].bx1) ? 34'(r_sb[LAT-1].bx1)
                                                               : 34'(r_sb[LAT-1].bx0)) + tol_ext;
            r_t1_bloy <= ((r_sb[LAT-1].by0 < r_sb[LAT-1].by1) ? 34'(r_sb[LAT-1].by0)
                                                               : 34'(r_sb[LAT-1].by1)) - tol_ext;
            r_t1_bhiy <= ((r_sb[LAT-1].by0 < r_sb[LAT-1].by1) ? 34'(r_sb[LAT-1].by1)
                                                               : 34'(r_sb[LAT-1].by0)) + tol_ext;
        end
    end

    assign px_ext = 34'(r_t1_px);
    assign py_ext = 34'(r_t1_py);

    // box test and output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_par <= r_t1_par;
            r_out_x   <= r_t1_px;
            r_out_y   <= r_t1_py;
            r_out_z   <= r_t1_z;
            r_out_hit <= !r_t1_par
                         && px_ext >= r_t1_alox && px_ext <= r_t1_ahix
                         && py_ext >= r_t1_aloy && py_ext <= r_t1_ahiy
                         && px_ext >= r_t1_blox && px_ext <= r_t1_bhix
                         && py_ext >= r_t1_bloy && py_ext <= r_t1_bhiy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_t1_valid  <= dv_valid;
            r_out_valid <= r_t1_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_z, r_out_y, r_out_x};
    assign o_m_axis_tuser  = {r_out_par, r_out_hit};

endmodule

/* dv/segment_intersection_2d_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the 2d segment intersection pipeline
module segment_intersection_2d_tb;
    import segx_pkg::*;

    typedef struct {
        logic   hit;
        logic   par;
        t_coord cx;
        t_coord cy;
        t_coord cz;
    } t_crossing;

    typedef logic signed [191:0] t_wide;

    localparam t_wide QMAX = 2147483647;
    localparam t_wide QMIN = -QMAX - 1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    logic [287:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // cross_x, cross_y, cross_z
    logic [95:0]  o_m_axis_tdata;
    // hit, parallel
    logic [1:0]   o_m_axis_tuser;

    t_pts        pair_queue[$];
    t_crossing   crossing_queue[$];
    t_pts        pair_on_bus;
    logic [15:0] tol_now = TOL_RESET;
    int          errors = 0;
    int          pairs_sent = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    int          parallels_seen = 0;
    int          saturated_seen = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    logic [15:0] stall_pattern = 16'hffff;

    segment_intersection_2d dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // sign-extend a coordinate into the wide working width
    function automatic t_wide widen(t_coord v);
        t_wide w;
        w = t_wide'(v);
        return w;
    endfunction

    // quotient truncated toward zero, clamped to the q16.16 range
    function automatic t_coord clamp_quotient(t_wide num, t_wide den);
        t_wide q;
        q = num / den;
        if (q > QMAX) return t_coord'(QMAX);
        if (q < QMIN) return t_coord'(QMIN);
        return t_coord'(q);
    endfunction

    function automatic logic inside_box(longint px, longint py, t_coord x0, t_coord y0,
                                        t_coord x1, t_coord y1, longint e);
        longint lx, hx, ly, hy;
        lx = (x0 < x1 ? x0 : x1) - e;
        hx = (x0 < x1 ? x1 : x0) + e;
        ly = (y0 < y1 ? y0 : y1) - e;
        hy = (y0 < y1 ? y1 : y0) + e;
        return px >= lx && px <= hx && py >= ly && py <= hy;
    endfunction

    // cramer solution of the two lines, then the widened box test
    function automatic t_crossing solve_crossing(t_pts p, logic [15:0] tol);
        t_wide     a1, b1, c1, a2, b2, c2, d, dx, dy;
        t_crossing r;
        a1 = widen(p.ay1) - widen(p.ay0);
        b1 = widen(p.ax0) - widen(p.ax1);
        c1 = widen(p.ax0) * a1 - widen(p.ay0) * (widen(p.ax1) - widen(p.ax0));
        a2 = widen(p.by1) - widen(p.by0);
        b2 = widen(p.bx0) - widen(p.bx1);
        c2 = widen(p.bx0) * a2 - widen(p.by0) * (widen(p.bx1) - widen(p.bx0));
        d  = a1 * b2 - a2 * b1;
        dx = c1 * b2 - c2 * b1;
        dy = a1 * c2 - a2 * c1;
        r.cz = p.az0;
        if (d == 0) begin
            r.hit = 1'b0;
            r.par = 1'b1;
            r.cx  = '0;
            r.cy  = '0;
        end else begin
            r.par = 1'b0;
            r.cx  = clamp_quotient(dx, d);
            r.cy  = clamp_quotient(dy, d);
            r.hit = inside_box(r.cx, r.cy, p.ax0, p.ay0, p.ax1, p.ay1, longint'(tol)) &&
                    inside_box(r.cx, r.cy, p.bx0, p.by0, p.bx1, p.by1, longint'(tol));
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, field, got, want);
        errors++;
    endtask

    function automatic t_pts make_pair(t_coord ax0, t_coord ay0, t_coord ax1, t_coord ay1,
                                       t_coord bx0, t_coord by0, t_coord bx1, t_coord by1);
        t_pts p;
        p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
        p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
        p.az0 = $urandom;
        return p;
    endfunction

    function automatic t_coord near_coord();
        return t_coord'((int'($urandom_range(0, 8000)) - 4000) * 1024);
    endfunction

    // random pair of one of several shapes, mostly segments that come close
    function automatic t_pts random_pair();
        t_pts   p;
        t_coord cx, cy, dxv, dyv;
        int     k;
        p = make_pair(near_coord(), near_coord(), near_coord(), near_coord(),
                      near_coord(), near_coord(), near_coord(), near_coord());
        case ($urandom_range(0, 9))
            0, 1: begin  // full range coordinates
                p = make_pair($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
            end
            2: begin  // parallel: b is a scaled shift of a
                k = $urandom_range(1, 3);
                dxv = p.ax1 - p.ax0;
                dyv = p.ay1 - p.ay0;
                p.bx1 = p.bx0 + dxv * k;
                p.by1 = p.by0 + dyv * k;
            end
            3: begin  // shared endpoint
                p.bx0 = p.ax1;
                p.by0 = p.ay1;
            end
            4: begin  // nearly parallel long lines, large quotients
                p.bx0 = p.ax0 + $urandom_range(0, 3);
                p.by0 = p.ay0 + 65536;
                p.bx1 = p.ax1 + $urandom_range(0, 3);
                p.by1 = p.ay1 + 65536;
            end
            5: begin  // axis aligned cross with its edge near the tolerance
                cx = near_coord();
                cy = near_coord();
                p = make_pair(cx - 65536, cy, cx, cy,
                              cx + $urandom_range(0, 65600), cy - 65536,
                              cx + 0, cy + 65536);
                p.bx1 = p.bx0;
            end
            default: ;
        endcase
        return p;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        logic next_valid;
        t_pts next_pair;
        next_valid = i_s_axis_tvalid;
        next_pair  = pair_on_bus;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                crossing_queue.push_back(solve_crossing(pair_on_bus, tol_now));
                pairs_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pair_queue.size() > 0) begin
                    next_pair  = pair_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        pair_on_bus     <= next_pair;
        i_s_axis_tvalid <= next_valid;
        i_s_axis_tdata  <= {next_pair.by1, next_pair.bx1, next_pair.by0, next_pair.bx0,
                            next_pair.ay1, next_pair.ax1, next_pair.az0, next_pair.ay0,
                            next_pair.ax0};
    end

    // receiver: modes of always ready, patterned stalls and heavy stalls
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode    = $urandom_range(0, 2);
            stall_timer   = $urandom_range(20, 120);
            stall_pattern = 16'($urandom);
        end else begin
            stall_timer--;
        end
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
        case (stall_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= stall_pattern[0];
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // monitor: each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (crossing_queue.size() == 0) begin
                $display("unexpected result transfer, nothing pending");
                errors++;
            end else begin
                want = crossing_queue.pop_front();
                if (o_m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", o_m_axis_tuser[0], want.hit);
                if (o_m_axis_tuser[1] !== want.par)
                    report_mismatch("parallel", o_m_axis_tuser[1], want.par);
                if (o_m_axis_tdata[31:0] !== want.cx)
                    report_mismatch("cross_x", t_coord'(o_m_axis_tdata[31:0]), want.cx);
                if (o_m_axis_tdata[63:32] !== want.cy)
                    report_mismatch("cross_y", t_coord'(o_m_axis_tdata[63:32]), want.cy);
                if (o_m_axis_tdata[95:64] !== want.cz)
                    report_mismatch("cross_z", t_coord'(o_m_axis_tdata[95:64]), want.cz);
                hits_seen      += want.hit;
                parallels_seen += want.par;
                if (!want.par && (want.cx == QMAX || want.cx == QMIN ||
                                  want.cy == QMAX || want.cy == QMIN))
                    saturated_seen++;
            end
            results_seen++;
        end
    end

    // sample between edges so queue and bus state have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pair_queue.size() != 0 || crossing_queue.size() != 0 || i_s_axis_tvalid);
        repeat (FRONT_LAT + 20) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        tol_now     <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [15:0] tol_list[5];
        t_coord      edge_x;
        tol_list = '{16'd0, 16'hffff, 16'd1, 16'd0, 16'd0};
        tol_list[3] = 16'($urandom);
        tol_list[4] = 16'($urandom_range(0, 300));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs under the reset tolerance
        edge_x = 10 * 65536;
        pair_queue.push_back(make_pair(0, 0, edge_x, 0, edge_x + 66, -65536, edge_x + 66, 65536));
        pair_queue.push_back(make_pair(0, 0, edge_x, 0, edge_x + 67, -65536, edge_x + 67, 65536));
        pair_queue.push_back(make_pair(-65536, -65536, 65536, 65536, -65536, 65536, 65536, -65536));
        pair_queue.push_back(make_pair(0, 0, 65536, 65536, 0, 65536, 65536, 131072));
        pair_queue.push_back(make_pair(0, 0, 65536, 65536, 131072, 131072, 196608, 196608));
        pair_queue.push_back(make_pair(5, 5, 5, 5, 7, 9, 7, 9));
        pair_queue.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pair_queue.push_back(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                       32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
        pair_queue.push_back(make_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                       32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        pair_queue.push_back(make_pair(32'h80000000, 0, 32'h7fffffff, 1,
                                       32'h80000000, 1, 32'h7fffffff, 3));
        pair_queue.push_back(make_pair(32'h7fffffff, 0, 32'h80000000, 1,
                                       32'h7fffffff, 1, 32'h80000000, 3));
        pair_queue.push_back(make_pair(0, 0, 65536, 0, 0, 1, 65536, 2));
        pair_queue.push_back(make_pair(32'hffffffff, 32'hffffffff, 32'h55555555, 32'haaaaaaaa,
                                       32'haaaaaaaa, 32'h55555555, 0, 32'hffffffff));
        pair_queue[0].az0 = 32'h80000000;
        pair_queue[1].az0 = 32'h7fffffff;
        wait_idle();

        // random phases, each under its own tolerance
        foreach (tol_list[i]) begin
            write_tolerance(tol_list[i]);
            repeat (210) pair_queue.push_back(random_pair());
            wait_idle();
        end

        $display("covered %0d pairs, tolerances 66, 0, 65535, 1 and two random values",
                 pairs_sent);
        $display("results %0d: hits %0d, parallel %0d, saturated %0d",
                 results_seen, hits_seen, parallels_seen, saturated_seen);
        if (errors == 0 && crossing_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
